/* rtl/assert_macros.svh */
// Assertion macros shared by checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

/* rtl/bfoa_pkg.sv */
// Shared types and codes for the best-fit offset allocator.
package bfoa_pkg;
  localparam int unsigned OffW = 20;
  localparam int unsigned SizeW = 21;
  localparam int unsigned MaxCapacity = 1048576;
  localparam int unsigned AlignBytes = 16;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_SPACE   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_ZERO_SIZE  = 3'd4;

  typedef struct packed {
    logic [1:0]       operation;
    logic [SizeW-1:0] request_size;
    logic [OffW-1:0]  free_offset;
  } in_word_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [OffW-1:0]  granted_offset;
    logic [SizeW-1:0] granted_size;
    logic [SizeW-1:0] bytes_in_use;
  } out_word_t;

  // one table entry
  typedef struct packed {
    logic [OffW-1:0]  start;
    logic [SizeW-1:0] len;
    logic             free;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_LAST, S_DECIDE, S_SHIFT_UP, S_SHIFT_UP_W,
    S_FIND, S_FIND_LAST, S_MERGE, S_MERGE_W, S_TOP, S_TOP_LAST, S_DONE
  } state_t;
endpackage

/* rtl/best_fit_offset_allocator_unit.sv */
// Top level of the best-fit offset allocator.
// Takes one command word when start is high and busy is low; answers with one
// result word, shown for one cycle under out_valid (no backpressure). The block
// table sits in one synchronous RAM with a registered read; a sequencer walks it.
// Steps from accept to result word: clear writes entry 0 directly; allocate
// scans every entry, then moves entries up one at a time to open a slot and
// writes it; free runs a find pass, then a merge pass that reads each entry
// once and copies it down, and a top pass over the current block count.
// busy is also high for the first cycle after reset while entry 0 is written.
// A capacity write rebuilds the table at once (only entry 0 and the count
// change; stale entries beyond the count are never read). cfg_ready is high
// only while idle.
module best_fit_offset_allocator_unit #(
  parameter int unsigned MAX_BLOCKS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  bfoa_pkg::in_word_t    in_word,
  output logic                  out_valid,
  output bfoa_pkg::out_word_t   out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [20:0]           cfg_data
);
  import bfoa_pkg::*;
  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned AW = (AlignBytes > 1) ? $clog2(AlignBytes) : 1;

  // block table RAM
  entry_t mem [MAX_BLOCKS];
  logic          we;
  logic [IW-1:0] waddr, raddr;
  entry_t        wdata, rdata_r;
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  state_t state_r, state_nxt;
  logic [SizeW-1:0] cap_r, cap_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SizeW-1:0] used_r, used_nxt;
  in_word_t cmd_r, cmd_nxt;
  logic [SizeW-1:0] sz_r, sz_nxt;
  logic [CW-1:0] i_r, i_nxt;           // read pointer
  logic [CW-1:0] j_r, j_nxt;           // write pointer / aux
  logic found_r, found_nxt;
  logic [IW-1:0] best_r, best_nxt;
  entry_t bent_r, bent_nxt;            // best or current accumulated entry
  logic [SizeW-1:0] top_r, top_nxt;
  out_word_t out_r, out_nxt;
  logic ov_r, ov_nxt;
  logic init_r;

  // effective capacity: saturate, then align down
  logic [SizeW-1:0] cap_eff;
  logic [SizeW-1:0] cap_sat;
  always_comb begin
    cap_sat = (cfg_data > SizeW'(MaxCapacity)) ? SizeW'(MaxCapacity) : cfg_data;
    cap_eff = (cap_sat / SizeW'(AlignBytes)) * SizeW'(AlignBytes);
  end

  // aligned request size (22 bits to hold the carry)
  logic [SizeW:0] req_up;
  assign req_up = ((({1'b0, in_word.request_size} + (SizeW+1)'(AlignBytes - 1))
                    >> AW) << AW);

  // entry 0 is written in the first cycle after reset, so hold off then too
  assign busy      = (state_r != S_IDLE) || init_r;
  assign cfg_ready = !busy && !start;
  assign out_valid = ov_r;
  assign out_word  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cap_r   <= SizeW'(65536);
      cnt_r   <= CW'(1);
      used_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cap_r   <= cap_nxt;
      cnt_r   <= cnt_nxt;
      used_r  <= used_nxt;
      ov_r    <= ov_nxt;
    end
    cmd_r <= cmd_nxt; sz_r <= sz_nxt; i_r <= i_nxt; j_r <= j_nxt;
    found_r <= found_nxt; best_r <= best_nxt; bent_r <= bent_nxt;
    top_r <= top_nxt; out_r <= out_nxt;
  end

  // entry 0 is rewritten by the reset sequence: first cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) init_r <= 1'b1;
    else init_r <= 1'b0;
  end

  // aligned size overflowed past the field: nothing can fit
  function automatic logic req_up_hi(in_word_t w);
    logic [SizeW:0] t;
    t = ({1'b0, w.request_size} + (SizeW+1)'(AlignBytes - 1)) >> AW;
    return t[SizeW-AW];
  endfunction

  logic [SizeW-1:0] rest;
  logic [SizeW:0] end_sum;
  always_comb begin
    state_nxt = state_r; cap_nxt = cap_r; cnt_nxt = cnt_r; used_nxt = used_r;
    cmd_nxt = cmd_r; sz_nxt = sz_r; i_nxt = i_r; j_nxt = j_r;
    found_nxt = found_r; best_nxt = best_r; bent_nxt = bent_r; top_nxt = top_r;
    out_nxt = out_r; ov_nxt = 1'b0;
    we = 1'b0; waddr = '0; wdata = '0; raddr = IW'(i_r);
    rest = bent_r.len - sz_r;
    end_sum = {2'b0, rdata_r.start} + {1'b0, rdata_r.len};
    case (state_r)
      S_IDLE: begin
        if (init_r) begin
          we = 1'b1; wdata = '{start: '0, len: cap_r, free: 1'b1};
        end else if (cfg_valid && cfg_ready) begin
          cap_nxt = cap_eff; used_nxt = '0;
          cnt_nxt = (cap_eff != '0) ? CW'(1) : '0;
          we = 1'b1; wdata = '{start: '0, len: cap_eff, free: 1'b1};
        end else if (start) begin
          cmd_nxt = in_word; i_nxt = '0; found_nxt = 1'b0;
          sz_nxt = req_up[SizeW-1:0];
          raddr = '0; i_nxt = CW'(1);
          out_nxt = '{status: ST_OK, granted_offset: '0, granted_size: '0,
                      bytes_in_use: used_r};
          case (in_word.operation)
            OP_ALLOC: begin
              if (in_word.request_size == '0) begin
                out_nxt.status = ST_ZERO_SIZE; state_nxt = S_DONE;
              end else if (cnt_r == '0) begin
                out_nxt.status = ST_NO_SPACE; state_nxt = S_DONE;
              end else begin
                state_nxt = (cnt_r == CW'(1)) ? S_SCAN_LAST : S_SCAN;
              end
            end
            OP_FREE: begin
              if (cnt_r == '0) begin
                out_nxt.status = ST_NOT_FOUND; state_nxt = S_DONE;
              end else begin
                state_nxt = (cnt_r == CW'(1)) ? S_FIND_LAST : S_FIND;
              end
            end
            OP_CLEAR: begin
              used_nxt = '0; cnt_nxt = (cap_r != '0) ? CW'(1) : '0;
              out_nxt.bytes_in_use = '0;
              we = 1'b1; wdata = '{start: '0, len: cap_r, free: 1'b1};
              state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      // rdata_r holds entry i_r-1
      S_SCAN, S_SCAN_LAST: begin
        if (rdata_r.free && {1'b0, rdata_r.len} >= {1'b0, sz_r} &&
            (!found_r || rdata_r.len < bent_r.len)) begin
          found_nxt = 1'b1; best_nxt = IW'(i_r - CW'(1)); bent_nxt = rdata_r;
        end
        i_nxt = i_r + CW'(1);
        if (state_r == S_SCAN_LAST) state_nxt = S_DECIDE;
        else if (i_r + CW'(1) == cnt_r) state_nxt = S_SCAN_LAST;
      end
      S_DECIDE: begin
        if (!found_r || req_up_hi(cmd_r)) begin
          out_nxt.status = ST_NO_SPACE; state_nxt = S_DONE;
        end else if (rest != '0 && cnt_r == CW'(MAX_BLOCKS)) begin
          out_nxt.status = ST_TABLE_FULL; state_nxt = S_DONE;
        end else begin
          used_nxt = used_r + sz_r;
          out_nxt.bytes_in_use = used_r + sz_r;
          out_nxt.granted_offset = bent_r.start; out_nxt.granted_size = sz_r;
          we = 1'b1; waddr = best_r;
          wdata = '{start: bent_r.start, len: sz_r, free: 1'b0};
          if (rest == '0) state_nxt = S_DONE;
          else begin
            j_nxt = cnt_r;  // next slot to fill by shifting up
            i_nxt = cnt_r;
            state_nxt = S_SHIFT_UP;
          end
        end
      end
      S_SHIFT_UP: begin
        if (j_r == CW'(best_r) + CW'(1)) begin
          we = 1'b1; waddr = IW'(j_r);
          wdata = '{start: bent_r.start + sz_r[OffW-1:0], len: rest, free: 1'b1};
          cnt_nxt = cnt_r + CW'(1);
          state_nxt = S_DONE;
        end else begin
          raddr = IW'(j_r - CW'(1));
          state_nxt = S_SHIFT_UP_W;
        end
      end
      S_SHIFT_UP_W: begin
        we = 1'b1; waddr = IW'(j_r); wdata = rdata_r;
        j_nxt = j_r - CW'(1);
        state_nxt = S_SHIFT_UP;
      end
      S_FIND, S_FIND_LAST: begin
        i_nxt = i_r + CW'(1);
        if (!rdata_r.free && rdata_r.start == cmd_r.free_offset &&
            rdata_r.len == cmd_r.request_size) begin
          we = 1'b1; waddr = IW'(i_r - CW'(1));
          wdata = '{start: rdata_r.start, len: rdata_r.len, free: 1'b1};
          used_nxt = used_r - rdata_r.len;
          out_nxt.bytes_in_use = used_r - rdata_r.len;
          // merge pass: i reads, j writes; bent holds pending entry
          raddr = '0; i_nxt = CW'(1); j_nxt = '0;
          state_nxt = S_MERGE_W;
          found_nxt = 1'b0;
        end else if (state_r == S_FIND_LAST) begin
          out_nxt.status = ST_NOT_FOUND; state_nxt = S_DONE;
        end else if (i_r + CW'(1) == cnt_r) begin
          state_nxt = S_FIND_LAST;
        end
      end
      // the freed mark is already in the RAM; entry i_r-1 is read again here
      S_MERGE_W: begin
        raddr = IW'(i_r - CW'(1));
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        // rdata_r = entry i_r-1
        if (!found_r) begin
          bent_nxt = rdata_r; found_nxt = 1'b1;
        end else if (bent_r.free && rdata_r.free &&
                     ({2'b0, bent_r.start} + {1'b0, bent_r.len}) ==
                     {{(SizeW+1-OffW){1'b0}}, rdata_r.start}) begin
          bent_nxt.len = bent_r.len + rdata_r.len;
        end else begin
          we = 1'b1; waddr = IW'(j_r); wdata = bent_r;
          j_nxt = j_r + CW'(1); bent_nxt = rdata_r;
        end
        if (i_r == cnt_r) begin
          state_nxt = S_TOP;
        end else begin
          i_nxt = i_r + CW'(1);
          state_nxt = S_MERGE_W;
        end
      end
      S_TOP: begin
        // flush the pending entry, set new count, start top pass
        if (i_r == cnt_r && found_r) begin
          we = 1'b1; waddr = IW'(j_r); wdata = bent_r;
          cnt_nxt = j_r + CW'(1);
          found_nxt = 1'b0;
          top_nxt = '0; i_nxt = '0;
        end else begin
          // rdata_r = entry i_r-1 when i_r > 0
          if (i_r != '0 && !rdata_r.free && end_sum[SizeW-1:0] > top_r)
            top_nxt = end_sum[SizeW-1:0];
          if (i_r == cnt_r) state_nxt = S_DONE;
          else begin
            raddr = IW'(i_r); i_nxt = i_r + CW'(1);
          end
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

/* rtl/bfoa_checker.sv */
// Port-level checker for the allocator, bound to the top level.
`include "assert_macros.svh"
module bfoa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input bfoa_pkg::out_word_t out_word,
  input logic                cfg_ready
);
  import bfoa_pkg::*;
  `CHK_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "accept must raise busy")
  `CHK_NEXT(a_one_shot, clk, rst_n, out_valid, !out_valid, "result strobe longer than one cycle")
  `CHK_IMPL(a_fail_zero, clk, rst_n, out_valid && out_word.status != ST_OK,
            out_word.granted_size == '0, "failure with nonzero size")
  `CHK_IMPL(a_cfg_idle, clk, rst_n, cfg_ready, !busy, "config ready while busy")
endmodule

bind best_fit_offset_allocator_unit bfoa_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_word(out_word), .cfg_ready(cfg_ready)
);
